/* rtl/partition_fit_allocator_core_assert.svh */
// ----------------------------------------------------------------------------
// partition_fit_allocator_core_assert
// Assertion macros for the allocator RTL.
// ----------------------------------------------------------------------------
`ifndef PARTITION_FIT_ALLOCATOR_CORE_ASSERT_SVH
`define PARTITION_FIT_ALLOCATOR_CORE_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define PFA_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled during reset.
`define PFA_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

/* rtl/pfa_pkg.sv */
// ----------------------------------------------------------------------------
// pfa_pkg
// Types and codes of the partition fit allocator.
// ----------------------------------------------------------------------------
package pfa_pkg;

   localparam int TYPE_W     = 1;
   localparam int STRATEGY_W = 2;
   localparam int SLOT_W     = 3;
   localparam int AMOUNT_W   = 16;
   localparam int STATUS_W   = 2;
   localparam int INDEX_W    = 3;
   localparam int COUNT_W    = 4;

   localparam logic [TYPE_W-1:0] REQ_DEFINE   = 1'b0;
   localparam logic [TYPE_W-1:0] REQ_ALLOCATE = 1'b1;

   localparam logic [STRATEGY_W-1:0] STRAT_FIRST    = 2'd0;
   localparam logic [STRATEGY_W-1:0] STRAT_BEST     = 2'd1;
   localparam logic [STRATEGY_W-1:0] STRAT_WORST    = 2'd2;
   localparam logic [STRATEGY_W-1:0] STRAT_RESERVED = 2'd3;

   localparam logic [STATUS_W-1:0] STATUS_ALLOCATED = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_FAILED    = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_DEFINED   = 2'd2;

   typedef enum logic [1:0] {
      S_IDLE,
      S_SCAN,
      S_WRITE,
      S_RESULT
   } pfa_state_type;

endpackage

/* rtl/pfa_ram.sv */
// ----------------------------------------------------------------------------
// pfa_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module pfa_ram #(
   parameter  int WIDTH  = 17,
   parameter  int DEPTH  = 8,
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic              clock,
   input  logic              we,
   input  logic [ADDR_W-1:0] waddr,
   input  logic [WIDTH-1:0]  wdata,
   input  logic              re,
   input  logic [ADDR_W-1:0] raddr,
   output logic [WIDTH-1:0]  rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem_ff[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

/* rtl/partition_fit_allocator_core.sv */
// ----------------------------------------------------------------------------
// partition_fit_allocator_core
// Fixed partition table with define and first/best/worst fit allocate.
//
//   channel  dir  handshake            payload
//   req      in   req_valid/req_ready  req_type, req_strategy, req_slot_index,
//                                      req_amount
//   rsp      out  rsp_valid/rsp_ready  rsp_status, rsp_chosen_index
//   csr      in   csr_valid/csr_ready  csr_partitions_in_use
//
// Define writes the table on accept, then gives its result. Allocate scans
// L = min(partitions_in_use, NUM_PARTITIONS) entries through the single read
// port of the table RAM (one entry per cycle), then writes back the pick on a
// grant before the result; a miss goes straight to the result. Rejected
// allocates (reserved strategy, L = 0) skip the scan.
// Reset clears the entry valid bits and holds req and csr not ready; an entry
// never written reads as free, size zero. A new request is taken while a
// result waits on rsp; a finished result holds the sequencer until rsp frees up.
// ----------------------------------------------------------------------------
`include "partition_fit_allocator_core_assert.svh"

module partition_fit_allocator_core
   import pfa_pkg::*;
#(
   parameter int NUM_PARTITIONS = 8,
   parameter int SIZE_BITS      = 16
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  logic [TYPE_W-1:0]     req_type,
   input  logic [STRATEGY_W-1:0] req_strategy,
   input  logic [SLOT_W-1:0]     req_slot_index,
   input  logic [AMOUNT_W-1:0]   req_amount,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic [STATUS_W-1:0]   rsp_status,
   output logic [INDEX_W-1:0]    rsp_chosen_index,
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [COUNT_W-1:0]    csr_partitions_in_use
);

   localparam int IDX_W = (NUM_PARTITIONS > 1) ? $clog2(NUM_PARTITIONS) : 1;
   localparam int CNT_W = $clog2(NUM_PARTITIONS + 1);
   localparam int ENT_W = SIZE_BITS + 1;

   pfa_state_type state_ff, state_in;

   logic [COUNT_W-1:0]        csr_ff, csr_in;
   logic [NUM_PARTITIONS-1:0] valid_ff, valid_in;
   logic [STRATEGY_W-1:0]     strat_ff, strat_in;
   logic [SIZE_BITS-1:0]      amount_ff, amount_in;
   logic [CNT_W-1:0]          limit_ff, limit_in;
   logic [CNT_W-1:0]          issue_ff, issue_in;
   logic                      eval_v_ff, eval_v_in;
   logic [IDX_W-1:0]          eval_idx_ff, eval_idx_in;
   logic                      found_ff, found_in;
   logic [IDX_W-1:0]          best_idx_ff, best_idx_in;
   logic [SIZE_BITS-1:0]      best_size_ff, best_size_in;
   logic [STATUS_W-1:0]       res_status_ff, res_status_in;
   logic [INDEX_W-1:0]        res_index_ff, res_index_in;
   logic                      rsp_valid_ff, rsp_valid_in;
   logic [STATUS_W-1:0]       rsp_status_ff, rsp_status_in;
   logic [INDEX_W-1:0]        rsp_index_ff, rsp_index_in;

   logic              ram_we, ram_re;
   logic [IDX_W-1:0]  ram_waddr, ram_raddr;
   logic [ENT_W-1:0]  ram_wdata, ram_rdata;

   logic [CNT_W-1:0]     limit_now;
   logic                 slot_ok;
   logic                 ent_valid, ent_taken, ent_fits, ent_better;
   logic [SIZE_BITS-1:0] ent_size;

   pfa_ram #(
      .WIDTH (ENT_W),
      .DEPTH (NUM_PARTITIONS)
   ) u_table (
      .clock (clock),
      .we    (ram_we),
      .waddr (ram_waddr),
      .wdata (ram_wdata),
      .re    (ram_re),
      .raddr (ram_raddr),
      .rdata (ram_rdata)
   );

   // count above the table acts as the table size
   always_comb begin
      if (int'(csr_ff) > NUM_PARTITIONS) begin
         limit_now = CNT_W'(NUM_PARTITIONS);
      end else begin
         limit_now = CNT_W'(csr_ff);
      end
   end

   assign slot_ok = int'(req_slot_index) < NUM_PARTITIONS;

   // entry under evaluation; an entry never written reads as free, size zero
   assign ent_valid = valid_ff[eval_idx_ff];
   assign ent_size  = ent_valid ? ram_rdata[SIZE_BITS-1:0] : '0;
   assign ent_taken = ent_valid & ram_rdata[SIZE_BITS];
   assign ent_fits  = !ent_taken && (ent_size >= amount_ff);
   assign ent_better = !found_ff
                     || ((strat_ff == STRAT_BEST)  && (ent_size < best_size_ff))
                     || ((strat_ff == STRAT_WORST) && (ent_size > best_size_ff));

   always_comb begin
      state_in      = state_ff;
      csr_in        = csr_ff;
      valid_in      = valid_ff;
      strat_in      = strat_ff;
      amount_in     = amount_ff;
      limit_in      = limit_ff;
      issue_in      = issue_ff;
      eval_v_in     = 1'b0;
      eval_idx_in   = eval_idx_ff;
      found_in      = found_ff;
      best_idx_in   = best_idx_ff;
      best_size_in  = best_size_ff;
      res_status_in = res_status_ff;
      res_index_in  = res_index_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_status_in = rsp_status_ff;
      rsp_index_in  = rsp_index_ff;
      req_ready     = 1'b0;
      csr_ready     = !reset;
      ram_we        = 1'b0;
      ram_waddr     = best_idx_ff;
      ram_wdata     = {1'b1, best_size_ff};
      ram_re        = 1'b0;
      ram_raddr     = issue_ff[IDX_W-1:0];

      if (csr_valid && csr_ready) begin
         csr_in = csr_partitions_in_use;
      end

      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         S_IDLE: begin
            req_ready = !reset;
            if (req_valid && req_ready) begin
               strat_in      = req_strategy;
               amount_in     = SIZE_BITS'(req_amount);
               limit_in      = limit_now;
               issue_in      = '0;
               found_in      = 1'b0;
               res_status_in = STATUS_FAILED;
               res_index_in  = '0;
               state_in      = S_RESULT;
               if (req_type == REQ_DEFINE) begin
                  if (slot_ok) begin
                     ram_we        = 1'b1;
                     ram_waddr     = IDX_W'(req_slot_index);
                     ram_wdata     = {1'b0, SIZE_BITS'(req_amount)};
                     res_status_in = STATUS_DEFINED;
                     res_index_in  = req_slot_index;
                  end
               end else if ((req_strategy != STRAT_RESERVED) && (limit_now != '0)) begin
                  state_in = S_SCAN;
               end
            end
         end

         S_SCAN: begin
            // read one entry per cycle, evaluate it the cycle after
            if (issue_ff < limit_ff) begin
               ram_re      = 1'b1;
               issue_in    = issue_ff + 1'b1;
               eval_v_in   = 1'b1;
               eval_idx_in = issue_ff[IDX_W-1:0];
            end
            if (eval_v_ff && ent_fits && ent_better) begin
               found_in     = 1'b1;
               best_idx_in  = eval_idx_ff;
               best_size_in = ent_size;
            end
            if (issue_ff == limit_ff) begin
               state_in = found_in ? S_WRITE : S_RESULT;
            end
         end

         S_WRITE: begin
            ram_we        = 1'b1;
            res_status_in = STATUS_ALLOCATED;
            res_index_in  = INDEX_W'(best_idx_ff);
            state_in      = S_RESULT;
         end

         S_RESULT: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = res_status_ff;
               rsp_index_in  = res_index_ff;
               state_in      = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase

      if (ram_we) begin
         valid_in[ram_waddr] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         csr_ff       <= '0;
         valid_ff     <= '0;
         eval_v_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         csr_ff       <= csr_in;
         valid_ff     <= valid_in;
         eval_v_ff    <= eval_v_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      strat_ff      <= strat_in;
      amount_ff     <= amount_in;
      limit_ff      <= limit_in;
      issue_ff      <= issue_in;
      eval_idx_ff   <= eval_idx_in;
      found_ff      <= found_in;
      best_idx_ff   <= best_idx_in;
      best_size_ff  <= best_size_in;
      res_status_ff <= res_status_in;
      res_index_ff  <= res_index_in;
      rsp_status_ff <= rsp_status_in;
      rsp_index_ff  <= rsp_index_in;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_status       = rsp_status_ff;
   assign rsp_chosen_index = rsp_index_ff;

   `PFA_ASSERT_NOW(a_scan_in_range, clock, reset, state_ff == S_SCAN,
      issue_ff <= limit_ff, "scan counter ran past the partition limit")

   `PFA_ASSERT_NOW(a_write_has_pick, clock, reset, state_ff == S_WRITE,
      found_ff && (CNT_W'(best_idx_ff) < limit_ff),
      "write-back without a valid pick")

   `PFA_ASSERT_NOW(a_no_write_in_scan, clock, reset, state_ff == S_SCAN,
      !ram_we, "table write during scan")

   `PFA_ASSERT_NEXT(a_grant_marked, clock, reset, state_ff == S_WRITE,
      valid_ff[$past(best_idx_ff)], "granted partition not marked written")

endmodule

/* dv/tb_partition_fit_allocator_core.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_partition_fit_allocator_core
// Self-checking bench for the partition fit allocator. A queue-fed driver
// sends define and allocate requests, and the monitor predicts each grant
// from its own copy of the partition table. Results are checked in order.
// The partition count is changed only while the block is idle.
// ----------------------------------------------------------------------------
module tb_partition_fit_allocator_core;
   import pfa_pkg::*;

   localparam int NUM_SLOTS      = 8;
   localparam int WATCHDOG_LIMIT = 4000;
   localparam int PHASE_ITEMS    = 150;
   localparam int RANDOM_PHASES  = 12;

   typedef struct packed {
      logic [TYPE_W-1:0]     kind;
      logic [STRATEGY_W-1:0] strategy;
      logic [SLOT_W-1:0]     slot;
      logic [AMOUNT_W-1:0]   amount;
   } alloc_req_type;

   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic [INDEX_W-1:0]  index;
   } grant_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_ready;
   logic [TYPE_W-1:0]     req_type = '0;
   logic [STRATEGY_W-1:0] req_strategy = '0;
   logic [SLOT_W-1:0]     req_slot_index = '0;
   logic [AMOUNT_W-1:0]   req_amount = '0;
   logic                  rsp_valid;
   logic                  rsp_ready = 1'b0;
   logic [STATUS_W-1:0]   rsp_status;
   logic [INDEX_W-1:0]    rsp_chosen_index;
   logic                  csr_valid = 1'b0;
   logic                  csr_ready;
   logic [COUNT_W-1:0]    csr_partitions_in_use = '0;

   // predicted table and count
   logic [AMOUNT_W-1:0] slot_size [NUM_SLOTS] = '{default: '0};
   logic                slot_taken [NUM_SLOTS] = '{default: 1'b0};
   logic [COUNT_W-1:0]  alloc_count = '0;

   alloc_req_type pending_reqs [$];
   grant_type     expected_grants [$];
   int            reqs_queued = 0;
   int            reqs_accepted = 0;
   int            mismatches = 0;
   int            quiet_cycles = 0;
   logic          req_took = 1'b0;
   logic          steady = 1'b0;

   partition_fit_allocator_core #(
      .NUM_PARTITIONS(NUM_SLOTS),
      .SIZE_BITS(AMOUNT_W)
   ) u_top (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_type(req_type),
      .req_strategy(req_strategy),
      .req_slot_index(req_slot_index),
      .req_amount(req_amount),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_status(rsp_status),
      .rsp_chosen_index(rsp_chosen_index),
      .csr_valid(csr_valid),
      .csr_ready(csr_ready),
      .csr_partitions_in_use(csr_partitions_in_use)
   );

   always #1 clock = ~clock;

   function automatic grant_type predict_grant(input alloc_req_type r);
      grant_type g;
      int        span;
      bit        hit;
      int        pick;
      g.status = STATUS_FAILED;
      g.index  = '0;
      hit      = 1'b0;
      pick     = 0;
      if (r.kind == REQ_DEFINE) begin
         if (r.slot < NUM_SLOTS) begin
            slot_size[r.slot]  = r.amount;
            slot_taken[r.slot] = 1'b0;
            g.status = STATUS_DEFINED;
            g.index  = r.slot;
         end
         return g;
      end
      if (r.strategy == STRAT_RESERVED) return g;
      span = (alloc_count > NUM_SLOTS) ? NUM_SLOTS : int'(alloc_count);
      for (int i = 0; i < span; i++) begin
         if (!slot_taken[i] && slot_size[i] >= r.amount) begin
            if (!hit) begin
               hit  = 1'b1;
               pick = i;
               if (r.strategy == STRAT_FIRST) break;
            end else if (r.strategy == STRAT_BEST) begin
               if (slot_size[i] < slot_size[pick]) pick = i;
            end else begin
               if (slot_size[i] > slot_size[pick]) pick = i;
            end
         end
      end
      if (hit) begin
         slot_taken[pick] = 1'b1;
         g.status = STATUS_ALLOCATED;
         g.index  = pick[INDEX_W-1:0];
      end
      return g;
   endfunction

   // sizes clustered so that ties and exact fits show up often
   function automatic logic [AMOUNT_W-1:0] pick_amount();
      case ($urandom_range(0, 5))
         0: return AMOUNT_W'($urandom);
         1: return AMOUNT_W'($urandom_range(0, 3));
         2: return 16'hFFFF - AMOUNT_W'($urandom_range(0, 1));
         3: return AMOUNT_W'($urandom_range(0, 255));
         default: return 16'h0100 * AMOUNT_W'($urandom_range(1, 4));
      endcase
   endfunction

   function automatic void queue_req(input logic [TYPE_W-1:0] kind,
                                     input logic [STRATEGY_W-1:0] strategy,
                                     input logic [SLOT_W-1:0] slot,
                                     input logic [AMOUNT_W-1:0] amount);
      alloc_req_type r;
      r.kind     = kind;
      r.strategy = strategy;
      r.slot     = slot;
      r.amount   = amount;
      pending_reqs.push_back(r);
      reqs_queued++;
   endfunction

   task automatic wait_idle();
      do @(negedge clock);
      while (reqs_accepted != reqs_queued || expected_grants.size() != 0);
   endtask

   task automatic write_partition_count(input logic [COUNT_W-1:0] n);
      @(negedge clock);
      csr_valid             <= 1'b1;
      csr_partitions_in_use <= n;
      do @(posedge clock);
      while (!csr_ready);
      alloc_count = n;
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   // request driver
   always @(negedge clock) begin : drive_req
      alloc_req_type nxt;
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_took) begin
         if (pending_reqs.size() != 0 && (steady || $urandom_range(0, 99) >= 21)) begin
            nxt = pending_reqs.pop_front();
            req_valid      <= 1'b1;
            req_type       <= nxt.kind;
            req_strategy   <= nxt.strategy;
            req_slot_index <= nxt.slot;
            req_amount     <= nxt.amount;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   always @(negedge clock) begin
      rsp_ready <= steady || ($urandom_range(0, 99) >= 21);
   end

   always @(posedge clock) begin
      req_took <= !reset && req_valid && req_ready;
   end

   // result checker, then prediction for a new transfer
   always @(posedge clock) begin : watch_ports
      grant_type     got;
      grant_type     want;
      alloc_req_type r;
      if (!reset) begin
         if (rsp_valid && rsp_ready) begin
            got.status = rsp_status;
            got.index  = rsp_chosen_index;
            if (expected_grants.size() == 0) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("[%0t] unexpected result: status %0d index %0d",
                           $time, got.status, got.index);
            end else begin
               want = expected_grants.pop_front();
               if (got.status !== want.status || got.index !== want.index) begin
                  mismatches++;
                  if (mismatches <= 10)
                     $display("[%0t] mismatch: status exp %0d got %0d, index exp %0d got %0d",
                              $time, want.status, got.status, want.index, got.index);
               end
            end
         end
         if (req_valid && req_ready) begin
            r.kind     = req_type;
            r.strategy = req_strategy;
            r.slot     = req_slot_index;
            r.amount   = req_amount;
            expected_grants.push_back(predict_grant(r));
            reqs_accepted++;
         end
      end
   end

   // watchdog on cycles with no transfer on any channel
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)
          || (csr_valid && csr_ready)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles + 1 >= WATCHDOG_LIMIT) begin
            $display("Verification failed");
            $finish;
         end
      end
   end

   initial begin : stimulus
      logic [COUNT_W-1:0] cfg;
      int                 span;
      int                 made;
      int                 burst;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // count still at reset value: nothing can be granted
      @(posedge clock);
      queue_req(REQ_ALLOCATE, STRAT_FIRST, 3'd0, 16'h0000);
      queue_req(REQ_DEFINE, STRAT_RESERVED, 3'd0, 16'hFFFF);
      wait_idle();

      write_partition_count(4'd8);
      @(posedge clock);
      queue_req(REQ_DEFINE, STRAT_FIRST, 3'd1, 16'h0000);
      queue_req(REQ_DEFINE, STRAT_BEST, 3'd2, 16'h0100);
      queue_req(REQ_DEFINE, STRAT_WORST, 3'd3, 16'h8000);
      queue_req(REQ_DEFINE, STRAT_FIRST, 3'd4, 16'h0100);
      queue_req(REQ_DEFINE, STRAT_FIRST, 3'd5, 16'hFFFF);
      queue_req(REQ_DEFINE, STRAT_FIRST, 3'd6, 16'h0001);
      queue_req(REQ_DEFINE, STRAT_FIRST, 3'd7, 16'h0100);
      queue_req(REQ_ALLOCATE, STRAT_FIRST, 3'd7, 16'h0000);
      queue_req(REQ_ALLOCATE, STRAT_BEST, 3'd0, 16'h0100);
      queue_req(REQ_ALLOCATE, STRAT_WORST, 3'd0, 16'h0001);
      queue_req(REQ_ALLOCATE, STRAT_RESERVED, 3'd0, 16'h0000);
      queue_req(REQ_ALLOCATE, STRAT_BEST, 3'd0, 16'h0000);
      queue_req(REQ_ALLOCATE, STRAT_FIRST, 3'd0, 16'hFFFF);
      queue_req(REQ_ALLOCATE, STRAT_WORST, 3'd0, 16'h0100);
      wait_idle();

      // count above the table size acts as the full table
      write_partition_count(4'd15);
      @(posedge clock);
      queue_req(REQ_DEFINE, STRAT_FIRST, 3'd0, 16'h0050);
      queue_req(REQ_DEFINE, STRAT_FIRST, 3'd3, 16'h0050);
      queue_req(REQ_ALLOCATE, STRAT_BEST, 3'd0, 16'h0040);
      queue_req(REQ_ALLOCATE, STRAT_WORST, 3'd0, 16'h0000);
      queue_req(REQ_ALLOCATE, STRAT_FIRST, 3'd0, 16'hFFFF);
      wait_idle();

      // define outside the in-use range, then widen the range to reach it
      write_partition_count(4'd2);
      @(posedge clock);
      queue_req(REQ_DEFINE, STRAT_FIRST, 3'd6, 16'hFFFF);
      queue_req(REQ_ALLOCATE, STRAT_WORST, 3'd0, 16'h1000);
      wait_idle();
      write_partition_count(4'd7);
      @(posedge clock);
      queue_req(REQ_ALLOCATE, STRAT_WORST, 3'd0, 16'h1000);
      wait_idle();

      for (int p = 0; p < RANDOM_PHASES; p++) begin
         case (p)
            1: cfg = 4'd0;
            2: cfg = 4'd15;
            5: cfg = 4'd1;
            default: cfg = (p % 2 == 0) ? 4'd8 : COUNT_W'($urandom_range(0, 15));
         endcase
         write_partition_count(cfg);
         span = (cfg > NUM_SLOTS) ? NUM_SLOTS : int'(cfg);
         @(posedge clock);
         steady = (p == 4);
         made = 0;
         while (made < PHASE_ITEMS) begin
            // refill some partitions, then send a burst of mostly allocates, up to span + 2
            burst = $urandom_range(1, 8);
            repeat (burst) begin
               if ($urandom_range(0, 99) < 10)
                  queue_req(TYPE_W'($urandom), STRATEGY_W'($urandom),
                            SLOT_W'($urandom), AMOUNT_W'($urandom));
               else if (span == 0 || $urandom_range(0, 99) < 15)
                  queue_req(REQ_DEFINE, STRATEGY_W'($urandom), SLOT_W'($urandom),
                            pick_amount());
               else
                  queue_req(REQ_DEFINE, STRATEGY_W'($urandom),
                            SLOT_W'($urandom_range(0, span - 1)), pick_amount());
            end
            made += burst;
            burst = $urandom_range(1, span + 2);
            repeat (burst) begin
               if ($urandom_range(0, 99) < 10)
                  queue_req(TYPE_W'($urandom), STRATEGY_W'($urandom),
                            SLOT_W'($urandom), AMOUNT_W'($urandom));
               else
                  queue_req(REQ_ALLOCATE, STRATEGY_W'($urandom_range(0, 2)),
                            SLOT_W'($urandom), pick_amount());
            end
            made += burst;
         end
         wait_idle();
         steady = 1'b0;
      end

      repeat (32) @(posedge clock);
      if (mismatches == 0 && expected_grants.size() == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule
